[rtl/fbm_pkg.sv]
// Shared constants, register map and arithmetic helpers for the fractal
// value noise block. No dependencies.
package fbm_pkg;

    localparam int MAX_OCTAVES_DEF = 16;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int OCT_LAT         = 8;    // register stages in one octave unit

    localparam int ADDR_W = 3;
    // register index is paddr[2]
    localparam logic REG_OCTAVE_COUNT = 1'b0;
    localparam logic REG_NOISE_SEED   = 1'b1;

    localparam logic [4:0] OCTAVE_COUNT_RST = 5'd6;
    localparam logic [31:0] NOISE_SEED_RST  = 32'd0;

    localparam logic [31:0] HASH_KX    = 32'd1619;
    localparam logic [31:0] HASH_KY    = 32'd31337;
    localparam logic [31:0] HASH_KZ    = 32'd6271;
    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_A = 32'd789221;
    localparam logic [31:0] HASH_ADD_B = 32'd1376312589;

    // floor(2^32 / (2^n - 1)); n = 1 is handled as a plain shift
    function automatic logic [31:0] recip_lookup(input logic [4:0] n);
        logic [31:0] r;
        case (n)
            5'd2:    r = 32'd1431655765;
            5'd3:    r = 32'd613566756;
            5'd4:    r = 32'd286331153;
            5'd5:    r = 32'd138547332;
            5'd6:    r = 32'd68174084;
            5'd7:    r = 32'd33818640;
            5'd8:    r = 32'd16843009;
            5'd9:    r = 32'd8405024;
            5'd10:   r = 32'd4198404;
            5'd11:   r = 32'd2098176;
            5'd12:   r = 32'd1048832;
            5'd13:   r = 32'd524352;
            5'd14:   r = 32'd262160;
            5'd15:   r = 32'd131076;
            5'd16:   r = 32'd65537;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    // (a*(65536-s) + b*s) >> 16, truncated
    function automatic logic [15:0] lerp(input logic [15:0] a, input logic [15:0] b,
                                         input logic [15:0] s);
        logic [32:0] acc;
        acc = 33'(a) * 33'(17'h10000 - 17'(s)) + 33'(b) * 33'(s);
        return acc[31:16];
    endfunction

endpackage

[rtl/fbm_point_if.sv]
// Request channel carrying one 3D point in signed fixed point.
// No dependencies.
interface fbm_point_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

[rtl/fbm_noise_if.sv]
// Result channel carrying one noise value in unsigned Q0.16.
// No dependencies.
interface fbm_noise_if;
    logic        valid;
    logic        ready;
    logic [15:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

[rtl/fbm_octave.sv]
// One octave of 3D value noise: lattice split, corner hashing and
// trilinear smoothstep blend in eight register stages. Uses fbm_pkg.
module fbm_octave #(
    parameter int OCT       = 0,
    parameter int FRAC_BITS = fbm_pkg::FRAC_BITS_DEF
) (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] px,
    input  logic signed [31:0] py,
    input  logic signed [31:0] pz,
    input  logic [31:0]        seed,
    output logic [15:0]        value
);
    import fbm_pkg::*;

    logic [31:0] pt     [3];
    logic [63:0] scaled [3];
    logic [31:0] lat    [3];
    logic [15:0] fq     [3];
    logic [31:0] kax    [3];

    logic [31:0] lin_reg [3][2];
    logic [15:0] f_reg   [3];
    logic [15:0] f2_reg  [3];

    logic [31:0] n_reg   [8];
    logic [15:0] s2_reg  [3];
    logic [31:0] sq_reg  [8];
    logic [31:0] n3_reg  [8];
    logic [15:0] s3_reg  [3];
    logic [31:0] m_reg   [8];
    logic [31:0] n4_reg  [8];
    logic [15:0] s4_reg  [3];
    logic [15:0] h_reg   [8];
    logic [15:0] s5_reg  [3];
    logic [15:0] e_reg   [4];
    logic [15:0] s6y_reg;
    logic [15:0] s6z_reg;
    logic [15:0] g_reg   [2];
    logic [15:0] s7z_reg;
    logic [15:0] value_reg;

    logic [31:0] seed_oct;

    assign pt[0] = px;
    assign pt[1] = py;
    assign pt[2] = pz;
    assign kax[0] = HASH_KX;
    assign kax[1] = HASH_KY;
    assign kax[2] = HASH_KZ;
    assign seed_oct = seed + 32'(OCT);

    genvar a;
    generate
        for (a = 0; a < 3; a++) begin : g_axis
            assign scaled[a] = {{32{pt[a][31]}}, pt[a]} << OCT;
            assign lat[a]    = scaled[a][FRAC_BITS +: 32];
            if (FRAC_BITS >= 16) begin : g_trunc
                assign fq[a] = scaled[a][FRAC_BITS-1 -: 16];
            end else begin : g_fill
                assign fq[a] = {scaled[a][FRAC_BITS-1:0], (16 - FRAC_BITS)'(0)};
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // stage 1: lattice terms and f squared
            for (int i = 0; i < 3; i++)
            begin
                lin_reg[i][0] <= lat[i] * kax[i];
                lin_reg[i][1] <= (lat[i] + 32'd1) * kax[i];
                f_reg[i]      <= fq[i];
                f2_reg[i]     <= 16'((32'(fq[i]) * 32'(fq[i])) >> 16);
            end
            // stage 2: corner seeds and smoothstep weights
            for (int c = 0; c < 8; c++)
            begin
                logic [31:0] n0;
                n0 = lin_reg[0][c & 1] + lin_reg[1][(c >> 1) & 1]
                   + lin_reg[2][(c >> 2) & 1] + seed_oct;
                n_reg[c] <= (n0 << 13) ^ n0;
            end
            for (int i = 0; i < 3; i++)
            begin
                logic [33:0] sp;
                sp = 34'(f2_reg[i]) * 34'(18'd196608 - {1'b0, f_reg[i], 1'b0});
                s2_reg[i] <= sp[31:16];
            end
            // stage 3: square
            for (int c = 0; c < 8; c++)
            begin
                sq_reg[c] <= n_reg[c] * n_reg[c];
                n3_reg[c] <= n_reg[c];
            end
            s3_reg <= s2_reg;
            // stage 4
            for (int c = 0; c < 8; c++)
            begin
                m_reg[c]  <= sq_reg[c] * HASH_MUL_A + HASH_ADD_A;
                n4_reg[c] <= n3_reg[c];
            end
            s4_reg <= s3_reg;
            // stage 5: corner values
            for (int c = 0; c < 8; c++)
            begin
                logic [31:0] r;
                r = n4_reg[c] * m_reg[c] + HASH_ADD_B;
                h_reg[c] <= r[30:15];
            end
            s5_reg <= s4_reg;
            // stage 6..8: blend along x, y, z
            for (int j = 0; j < 4; j++)
                e_reg[j] <= lerp(h_reg[2*j], h_reg[2*j+1], s5_reg[0]);
            s6y_reg <= s5_reg[1];
            s6z_reg <= s5_reg[2];
            for (int k = 0; k < 2; k++)
                g_reg[k] <= lerp(e_reg[2*k], e_reg[2*k+1], s6y_reg);
            s7z_reg <= s6z_reg;
            value_reg <= lerp(g_reg[0], g_reg[1], s7z_reg);
        end
    end

    assign value = value_reg;

endmodule

[rtl/fbm_value_noise_3d.sv]
// Fractal value noise over up to MAX_OCTAVES octaves, one octave unit each.
// Pipeline from request to result: eight octave stages, term select, adder tree,
// normalize multiply, saturate. Throughput: one point per cycle; a stall on the
// result side freezes all stages.
// Reset clears the valid bits and sets 6 octaves and seed 0.
module fbm_value_noise_3d #(
    parameter int MAX_OCTAVES = fbm_pkg::MAX_OCTAVES_DEF,
    parameter int FRAC_BITS   = fbm_pkg::FRAC_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [fbm_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    fbm_point_if.sink                   point,
    fbm_noise_if.source                 noise
);
    import fbm_pkg::*;

    localparam int LVL   = $clog2(MAX_OCTAVES);
    localparam int NPAD  = 1 << LVL;
    localparam int DEPTH = OCT_LAT + 2 + LVL;

    logic [4:0]  octave_count_reg;
    logic [31:0] noise_seed_reg;
    logic [4:0]  n_eff;

    logic                en;
    logic [DEPTH-1:0]    vld_reg;
    logic [15:0]         oct_val [MAX_OCTAVES];
    logic [31:0]         tree_reg [LVL+1][NPAD];
    logic [63:0]         prod_reg;
    logic [63:0]         prod_next;
    logic                out_valid_reg;
    logic [15:0]         noise_value_reg;
    logic [15:0]         noise_value_next;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_NOISE_SEED) ? noise_seed_reg
                                                 : {27'd0, octave_count_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg <= OCTAVE_COUNT_RST;
            noise_seed_reg   <= NOISE_SEED_RST;
        end
        else if (psel && penable && pwrite)
        begin
            if (paddr[2] == REG_OCTAVE_COUNT)
                octave_count_reg <= pwdata[4:0];
            else
                noise_seed_reg <= pwdata;
        end
    end

    assign n_eff = (octave_count_reg > 5'(MAX_OCTAVES)) ? 5'(MAX_OCTAVES) : octave_count_reg;

    // advance when the output register is free or being drained
    assign en          = !out_valid_reg || noise.ready;
    assign point.ready = en;

    genvar i;
    generate
        for (i = 0; i < MAX_OCTAVES; i++) begin : g_oct
            fbm_octave #(
                .OCT       (i),
                .FRAC_BITS (FRAC_BITS)
            ) u_oct (
                .clk   (clk),
                .en    (en),
                .px    (point.point_x),
                .py    (point.point_y),
                .pz    (point.point_z),
                .seed  (noise_seed_reg),
                .value (oct_val[i])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[DEPTH-2:0], point.valid};
            out_valid_reg <= vld_reg[DEPTH-1];
        end
    end

    always_comb
    begin
        if (n_eff == 5'd1)
            prod_next = {tree_reg[LVL][0], 32'd0};
        else
            prod_next = 64'(tree_reg[LVL][0]) * 64'(recip_lookup(n_eff));
        noise_value_next = (prod_reg[63:32] > 32'hffff) ? 16'hffff : prod_reg[47:32];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // weight octave i by 2^(n-1-i), drop octaves past the count
            for (int k = 0; k < NPAD; k++)
            begin
                if (k < MAX_OCTAVES && 5'(k) < n_eff)
                    tree_reg[0][k] <= 32'(oct_val[k]) << (n_eff - 5'(k) - 5'd1);
                else
                    tree_reg[0][k] <= 32'd0;
            end
            for (int l = 0; l < LVL; l++)
                for (int j = 0; j < (NPAD >> (l + 1)); j++)
                    tree_reg[l+1][j] <= tree_reg[l][2*j] + tree_reg[l][2*j+1];
            prod_reg        <= prod_next;
            noise_value_reg <= noise_value_next;
        end
    end

    assign noise.valid       = out_valid_reg;
    assign noise.noise_value = noise_value_reg;

endmodule
